FILE: rtl/ctd_pkg.sv
// Shared types and constants for the chunked transfer decoder.
// Used by ctd_step, ctd_out_reg and chunked_transfer_decoder_unit; no dependencies.
`default_nettype none
package ctd_pkg;

	localparam int unsigned MAX_BODY = 1048576;
	localparam int unsigned LEN_W = 21;
	localparam int unsigned SIZE_W = 32;
	localparam logic [LEN_W-1:0] LEN_FIELD_MAX = {LEN_W{1'b1}};
	localparam logic [LEN_W-1:0] LEN_CAP =
		(MAX_BODY < (1 << LEN_W)) ? LEN_W'(MAX_BODY) : LEN_FIELD_MAX;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [2:0] {
		PH_SKIP   = 3'd0,
		PH_SIZE   = 3'd1,
		PH_HDR_LF = 3'd2,
		PH_DATA   = 3'd3,
		PH_DONE   = 3'd4
	} ctd_phase_t;

	typedef struct packed {
		ctd_phase_t        phase;
		logic [SIZE_W-1:0] size_acc;
		logic [SIZE_W-1:0] data_left;
		logic [LEN_W-1:0]  emitted;
	} ctd_state_t;

	typedef struct packed {
		logic             present;
		logic [7:0]       pbyte;
		logic             pvalid;
		logic             done;
		logic [LEN_W-1:0] length;
	} ctd_result_t;

	localparam ctd_state_t CTD_STATE_RESET = '{
		phase: PH_SKIP, size_acc: '0, data_left: '0, emitted: '0};

endpackage
`default_nettype wire

FILE: rtl/ctd_step.sv
// Combinational decode of one body byte against the current parser state.
// Depends on ctd_pkg for the state and result structs.
`default_nettype none
module ctd_step (
	input  var ctd_pkg::ctd_state_t  cur,
	input  var logic [7:0]           body_byte,
	input  var logic                 body_end,
	output ctd_pkg::ctd_state_t      nxt,
	output ctd_pkg::ctd_result_t     res
);
	import ctd_pkg::*;

	logic       is_ws;
	logic       is_hex;
	logic [3:0] hex_val;
	logic [SIZE_W-1:0] acc_digit;

	always_comb begin
		is_ws = (body_byte == CH_SP) || (body_byte == CH_TAB) ||
			(body_byte == CH_CR) || (body_byte == CH_LF);
		is_hex = 1'b1;
		hex_val = 4'd0;
		if (body_byte >= 8'h30 && body_byte <= 8'h39) begin
			hex_val = 4'(body_byte - 8'h30);
		end else if (body_byte >= 8'h61 && body_byte <= 8'h66) begin
			hex_val = 4'(body_byte - 8'h57);
		end else if (body_byte >= 8'h41 && body_byte <= 8'h46) begin
			hex_val = 4'(body_byte - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
	end

	// Accumulator after taking a digit; the size saturates at all ones.
	function automatic logic [SIZE_W-1:0] add_digit(input logic [SIZE_W-1:0] acc,
			input logic [3:0] v);
		if (acc[SIZE_W-1 -: 4] != 4'd0) begin
			return {SIZE_W{1'b1}};
		end
		return {acc[SIZE_W-5:0], v};
	endfunction

	assign acc_digit = add_digit(cur.size_acc, hex_val);

	always_comb begin
		logic was_done;
		logic take;
		logic end_hdr;
		logic [SIZE_W-1:0] acc;
		was_done = (cur.phase == PH_DONE);
		nxt = cur;
		res = '0;
		take = 1'b0;
		end_hdr = 1'b0;
		acc = cur.size_acc;

		case (cur.phase)
			PH_SKIP: begin
				if (!is_ws) begin
					acc = '0;
					if (body_byte == CH_PLUS || body_byte == CH_MINUS) begin
						nxt.phase = PH_SIZE;
					end else if (is_hex) begin
						acc = {{(SIZE_W-4){1'b0}}, hex_val};
						nxt.phase = PH_SIZE;
					end else begin
						end_hdr = 1'b1;
					end
				end
			end
			PH_SIZE: begin
				if (is_hex) begin
					acc = acc_digit;
				end else begin
					end_hdr = 1'b1;
				end
			end
			PH_HDR_LF: begin
				if (body_byte == CH_LF) begin
					nxt.phase = PH_DATA;
				end else begin
					take = 1'b1;
				end
			end
			PH_DATA: take = 1'b1;
			default: nxt.phase = PH_DONE;
		endcase
		nxt.size_acc = acc;

		if (end_hdr) begin
			if (acc == '0) begin
				res.done = 1'b1;
				nxt.phase = PH_DONE;
			end else begin
				nxt.data_left = acc;
				if (body_byte == CH_CR) begin
					nxt.phase = PH_HDR_LF;
				end else if (body_byte == CH_LF) begin
					nxt.phase = PH_DATA;
				end else begin
					take = 1'b1;
				end
			end
		end

		if (take) begin
			res.pbyte = body_byte;
			res.pvalid = 1'b1;
			if (cur.emitted < LEN_CAP) begin
				nxt.emitted = cur.emitted + 1'b1;
			end
			if (nxt.data_left != '0) begin
				nxt.data_left = nxt.data_left - 1'b1;
			end
			nxt.phase = (nxt.data_left == '0) ? PH_SKIP : PH_DATA;
		end

		if (body_end && !was_done) begin
			res.done = 1'b1;
		end
		res.length = nxt.emitted;
		res.present = res.pvalid || res.done;

		// The end of the body starts a fresh message with the next byte.
		if (body_end) begin
			nxt = CTD_STATE_RESET;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/ctd_out_reg.sv
// Result register of the decoder with its stream handshake toward the receiver.
// Depends on ctd_pkg for the result struct.
`default_nettype none
module ctd_out_reg (
	input  var logic                 clk,
	input  var logic                 arst_n,
	input  var logic                 load,
	input  var ctd_pkg::ctd_result_t din,
	output logic                     busy,
	output logic                     m_tvalid,
	input  var logic                 m_tready,
	output logic [31:0]              m_tdata,
	output logic                     m_tuser,
	output logic                     m_tlast
);
	import ctd_pkg::*;

	logic        valid_q;
	ctd_result_t res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= din;
		end
	end

	// The register can take a new result when empty or being drained.
	assign busy = valid_q && !m_tready;
	assign m_tvalid = valid_q;
	assign m_tdata = {3'b000, res_q.length, res_q.pbyte};
	assign m_tuser = res_q.pvalid;
	assign m_tlast = res_q.done;

endmodule
`default_nettype wire

FILE: rtl/chunked_transfer_decoder_unit.sv
// Chunked transfer decoder: turns a chunked HTTP body byte stream into payload bytes.
// Instantiates ctd_step and ctd_out_reg; depends on ctd_pkg.
//
// Input channel (s_*): one body byte per item, s_tlast marks the last byte of the body.
// Output channel (m_*): at most one item per input byte. m_tuser is 1 when m_tdata[7:0]
// holds a payload byte; m_tlast is 1 on the item that ends the message, and
// m_tdata[28:8] then holds the final payload length (otherwise the running count).
// Header bytes, separators and bytes after the terminating zero chunk give no item.
// Throughput is one byte per cycle while the result register is not held by a stalled
// receiver: the parser state advances when the byte in the input register moves on.
// A byte accepted into the input register is decoded there and lands in the result
// register once that register is free.
// Reset clears the parser to the start of a message and empties both registers.
// When the receiver stalls, one result waits in the result register while one more
// byte waits in the input register; s_tready falls only when both are held.
`default_nettype none
module chunked_transfer_decoder_unit (
	input  var logic        clk,
	input  var logic        arst_n,
	input  var logic        s_tvalid,
	output logic            s_tready,
	input  var logic [7:0]  s_tdata,   // [7:0] body_byte
	input  var logic        s_tlast,   // body_end
	output logic            m_tvalid,
	input  var logic        m_tready,
	output logic [31:0]     m_tdata,   // [7:0] payload_byte, [28:8] payload_length, rest zero
	output logic            m_tuser,   // payload_valid
	output logic            m_tlast    // message_done
);
	import ctd_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	ctd_state_t  state_q;
	ctd_state_t  state_nxt;
	ctd_result_t res;
	logic        out_busy;
	logic        advance;

	assign advance = valid_s1 && !out_busy;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CTD_STATE_RESET;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	ctd_step u_step (
		.cur       (state_q),
		.body_byte (byte_s1),
		.body_end  (last_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	ctd_out_reg u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance && res.present),
		.din      (res),
		.busy     (out_busy),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

FILE: test/tb_chunked_transfer_decoder_unit.sv
// Self-checking testbench for chunked_transfer_decoder_unit: short directed bodies, then
// random chunked messages, with stalls on both stream sides.
// Depends on ctd_pkg and the decoder RTL only.
module tb_chunked_transfer_decoder_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ctd_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 500_000;
	localparam int unsigned ITEM_TARGET = 410;
	localparam int unsigned DRAIN_CYCLES = 20;

	typedef struct packed {
		logic [7:0]       pbyte;
		logic             pvalid;
		logic             done;
		logic [LEN_W-1:0] length;
	} payload_result_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
		bit         dropped;
	} body_item_t;

	// Tracks the decoder state for every accepted body byte and holds the
	// payload items that the output stream still owes.
	class payload_scoreboard;
		ctd_phase_t        phase;
		logic [SIZE_W-1:0] size_acc;
		logic [SIZE_W-1:0] data_left;
		logic [LEN_W-1:0]  emitted;
		payload_result_t   cur;
		payload_result_t   expected_q[$];
		int                errors;

		function new();
			errors = 0;
			clear_message();
		endfunction

		function void clear_message();
			phase = PH_SKIP;
			size_acc = '0;
			data_left = '0;
			emitted = '0;
		endfunction

		function int hex_digit_value(logic [7:0] b);
			if (b >= 8'h30 && b <= 8'h39) return int'(b - 8'h30);
			if (b >= 8'h61 && b <= 8'h66) return int'(b - 8'h61) + 10;
			if (b >= 8'h41 && b <= 8'h46) return int'(b - 8'h41) + 10;
			return -1;
		endfunction

		function void add_digit(int v);
			logic [SIZE_W+3:0] n;
			n = {size_acc, 4'(v)};
			size_acc = (n[SIZE_W+3:SIZE_W] != 4'd0) ? {SIZE_W{1'b1}} : n[SIZE_W-1:0];
		endfunction

		function void take_data(logic [7:0] b);
			cur.pbyte = b;
			cur.pvalid = 1'b1;
			if (emitted < LEN_CAP) emitted++;
			if (data_left != '0) data_left--;
			phase = (data_left == '0) ? PH_SKIP : PH_DATA;
		endfunction

		// A non-digit ends the size; a zero size ends the message instead.
		function void end_header(logic [7:0] b);
			if (size_acc == '0) begin
				cur.done = 1'b1;
				phase = PH_DONE;
			end else begin
				data_left = size_acc;
				if (b == CH_CR) phase = PH_HDR_LF;
				else if (b == CH_LF) phase = PH_DATA;
				else take_data(b);
			end
		endfunction

		function void note_body_byte(logic [7:0] b, logic last);
			logic was_done;
			int v;
			was_done = (phase == PH_DONE);
			cur = '0;
			v = hex_digit_value(b);
			case (phase)
			PH_SKIP: begin
				if (!(b == CH_SP || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
					size_acc = '0;
					if (b == CH_PLUS || b == CH_MINUS) begin
						phase = PH_SIZE;
					end else if (v >= 0) begin
						add_digit(v);
						phase = PH_SIZE;
					end else begin
						end_header(b);
					end
				end
			end
			PH_SIZE: begin
				if (v >= 0) add_digit(v);
				else end_header(b);
			end
			PH_HDR_LF: begin
				if (b == CH_LF) phase = PH_DATA;
				else take_data(b);
			end
			PH_DATA: take_data(b);
			default: phase = PH_DONE;
			endcase
			if (last && !was_done) cur.done = 1'b1;
			cur.length = emitted;
			if (cur.pvalid || cur.done) expected_q.push_back(cur);
			if (last) clear_message();
		endfunction

		function void check_payload(logic [7:0] pbyte, logic pvalid, logic done,
				logic [LEN_W-1:0] length, logic [2:0] pad);
			payload_result_t exp_item;
			if (expected_q.size() == 0) begin
				$error("unexpected item: payload_byte %0h payload_valid %0b message_done %0b",
					pbyte, pvalid, done);
				errors++;
			end else begin
				exp_item = expected_q.pop_front();
				if (pbyte !== exp_item.pbyte) begin
					$error("payload_byte: expected %0h, got %0h", exp_item.pbyte, pbyte);
					errors++;
				end
				if (pvalid !== exp_item.pvalid) begin
					$error("payload_valid: expected %0b, got %0b", exp_item.pvalid, pvalid);
					errors++;
				end
				if (done !== exp_item.done) begin
					$error("message_done: expected %0b, got %0b", exp_item.done, done);
					errors++;
				end
				if (length !== exp_item.length) begin
					$error("payload_length: expected %0d, got %0d", exp_item.length, length);
					errors++;
				end
				if (pad !== 3'd0) begin
					$error("tdata padding: expected 0, got %0h", pad);
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	payload_scoreboard sb = new();
	body_item_t  body_q[$];
	bit          src_idle = 1'b0;
	bit          snk_idle = 1'b0;
	int unsigned counted_items = 0;
	int unsigned cycle_count = 0;

	chunked_transfer_decoder_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_payload(m_tdata[7:0], m_tuser, m_tlast, m_tdata[28:8], m_tdata[31:29]);
	end

	// Receiver: random stall bursts while snk_idle is set.
	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (snk_idle && $urandom_range(0, 5) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// s_tvalid is left high after an accepted item, so the next call must
	// follow in the same time step or the caller must lower it first.
	task automatic push_body_byte(input logic [7:0] b, input logic last);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		sb.note_body_byte(b, last);
	endtask

	task automatic play_message();
		foreach (body_q[i]) begin
			push_body_byte(body_q[i].b, body_q[i].last);
			if (!body_q[i].dropped) counted_items++;
		end
		body_q.delete();
	endtask

	function automatic void add_byte(logic [7:0] b, bit dropped = 1'b0);
		body_q.push_back('{b: b, last: 1'b0, dropped: dropped});
	endfunction

	function automatic void mark_last();
		body_q[body_q.size() - 1].last = 1'b1;
	endfunction

	function automatic logic [7:0] hex_char(int unsigned d);
		if (d < 10) return 8'h30 + 8'(d);
		return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'(d - 10);
	endfunction

	function automatic logic [7:0] pick_space();
		case ($urandom_range(0, 3))
		0: return CH_SP;
		1: return CH_TAB;
		2: return CH_CR;
		default: return CH_LF;
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 3))
		0: return hex_char($urandom_range(0, 15));
		1: return pick_space();
		2: return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
		default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void build_chunk_header(int unsigned sz);
		int unsigned nib;
		repeat ($urandom_range(0, 3)) add_byte(pick_space());
		if ($urandom_range(0, 7) == 0) add_byte($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
		repeat ($urandom_range(0, 2)) add_byte("0");
		nib = 1;
		while (nib < 8 && (sz >> (4 * nib)) != 0) nib++;
		for (int i = int'(nib) - 1; i >= 0; i--) add_byte(hex_char((sz >> (4 * i)) & 15));
		case ($urandom_range(0, 9))
		7: add_byte(CH_LF);
		8: add_byte(CH_CR);
		9: ;
		default: begin
			add_byte(CH_CR);
			add_byte(CH_LF);
		end
		endcase
	endfunction

	// One message of one to three chunks, the zero chunk and up to three trailing bytes.
	function automatic void build_message();
		int unsigned sz;
		repeat ($urandom_range(1, 3)) begin
			sz = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 200) : $urandom_range(1, 12);
			build_chunk_header(sz);
			repeat (sz) add_byte(8'($urandom_range(0, 255)));
			if ($urandom_range(0, 3) != 0) begin
				add_byte(CH_CR);
				add_byte(CH_LF);
			end
		end
		build_chunk_header(0);
		repeat ($urandom_range(0, 3)) add_byte(noise_byte(), 1'b1);
		mark_last();
	endfunction

	initial begin
		int unsigned cut;
		int unsigned kind;
		bit pressured;
		bit tail;
		pressured = 1'b0;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// LF-only header, an all-ones data byte, body end on a size digit.
		add_byte("1");
		add_byte(CH_LF);
		add_byte(8'hFF);
		add_byte("0");
		mark_last();
		play_message();
		// Signed size whose terminator is itself a data byte, then the zero
		// chunk and a dropped byte.
		add_byte(CH_MINUS);
		add_byte("2");
		add_byte(8'h00);
		add_byte("z");
		add_byte(CH_TAB);
		add_byte("0");
		add_byte(CH_CR);
		add_byte("x", 1'b1);
		mark_last();
		play_message();
		// A header without digits ends the message at once.
		add_byte("G");
		add_byte("k", 1'b1);
		mark_last();
		play_message();
		add_byte(CH_PLUS);
		add_byte(CH_CR);
		mark_last();
		play_message();
		// Size saturates at all ones; the body ends early inside the chunk.
		add_byte("f");
		repeat (8) add_byte("F");
		add_byte(CH_LF);
		add_byte(8'h80);
		add_byte(8'h7F);
		mark_last();
		play_message();

		while (counted_items < ITEM_TARGET) begin
			tail = counted_items > ITEM_TARGET - 75;
			src_idle = !tail && $urandom_range(0, 3) != 0;
			snk_idle = !tail && $urandom_range(0, 3) != 0;
			if (!pressured && counted_items >= 250) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
				while (sb.pending() != 0) @(posedge clk);
				pressured = 1'b1;
			end
			kind = $urandom_range(0, 9);
			if (kind == 0) begin
				repeat ($urandom_range(1, 8)) add_byte(noise_byte());
				mark_last();
			end else begin
				build_message();
				if (kind == 1) begin
					cut = $urandom_range(0, body_q.size() - 1);
					while (body_q.size() > cut + 1) void'(body_q.pop_back());
					mark_last();
				end
			end
			play_message();
		end
		s_tvalid <= 1'b0;

		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected items never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
